// File: rtl/core/dictionary_message_decoder_core_defines.svh
// Assertion macros for the dictionary message decoder checker.
// No dependencies; included by the checker file.
`ifndef DICTIONARY_MESSAGE_DECODER_CORE_DEFINES_SVH
`define DICTIONARY_MESSAGE_DECODER_CORE_DEFINES_SVH

// Same-cycle implication.
`define DMD_ASSERT_NOW(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("dmd check failed");

// Next-cycle implication.
`define DMD_ASSERT_NEXT(label, ck, rs, ante, cons) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("dmd check failed");

`endif

// File: rtl/core/dmd_pkg.sv
// Shared types and constants of the dictionary message decoder.
// No dependencies.
package dmd_pkg;

  localparam int LOAD_AW  = 12;
  localparam int OFF_W    = 13;
  localparam int POS_W    = 14;
  localparam int WIDX_W   = 14;
  localparam int WOFF_AW  = 15;
  localparam int NUM_W    = 9;
  localparam int MOFF_AW  = 10;

  localparam int CODE_BIT = 7;
  localparam int WIDE_BIT = 6;

  localparam logic [7:0] SPACE_CHAR = 8'h20;
  localparam logic [7:0] NUL_CHAR   = 8'h00;

  typedef enum logic [2:0] {
    REQ_DECODE  = 3'd0,
    REQ_LD_MSG  = 3'd1,
    REQ_LD_WORD = 3'd2,
    REQ_LD_WOFF = 3'd3,
    REQ_LD_MOFF = 3'd4
  } req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MOFF0,
    ST_MOFF1,
    ST_MOFF2,
    ST_LOOP,
    ST_LEAD,
    ST_IDX2,
    ST_WOFF0,
    ST_WOFF1,
    ST_WOFF2,
    ST_RSTART,
    ST_RANGE,
    ST_FLUSH
  } st_t;

  typedef struct packed {
    logic [POS_W-1:0]   msg_addr;
    logic [POS_W-1:0]   word_addr;
    logic [WOFF_AW-1:0] woff_addr;
    logic [MOFF_AW-1:0] moff_addr;
  } rd_req_t;

  typedef struct packed {
    logic [7:0]       msg_byte;
    logic [7:0]       word_byte;
    logic [OFF_W-1:0] woff;
    logic [OFF_W-1:0] moff;
  } rd_data_t;

endpackage

// File: rtl/core/dictionary_message_decoder_core.sv
// Top level of the dictionary message decoder: load decode, stores, sequencer.
// Depends on dmd_pkg, dmd_store and dmd_walker.
//
// Usage: present an item on req_type, load_addr, load_data and message_number
// with start high; it is taken at a rising edge where busy is low.
// Load items write one store entry at that edge (none when load_addr is past
// the store) and produce no results; busy stays low. A decode item raises busy
// and emits results one per strobe cycle on out_char, last and truncated:
// characters first, then a zero terminator with last high. busy falls in the
// cycle the terminator is shown, so the next item may be taken at the edge that
// ends it. Decode steps: fetch the message bounds, then for each leader read
// it, read the second index byte of a wide code and look up the word offsets,
// then walk the word or literal run one character at a time; the registered
// store read ports set this pace.
// Reset (rst, synchronous) returns the sequencer to idle; store contents are
// kept and are undefined until written. The receiver cannot stall: every
// result is valid for exactly one cycle.
module dictionary_message_decoder_core #(
  parameter int MSG_TEXT_DEPTH  = 4096,
  parameter int WORD_TEXT_DEPTH = 4096,
  parameter int WORD_COUNT      = 1024,
  parameter int MSG_COUNT       = 512,
  parameter int MAX_CHARS       = 63
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    req_type,
  input  logic [dmd_pkg::LOAD_AW-1:0]   load_addr,
  input  logic [dmd_pkg::OFF_W-1:0]     load_data,
  input  logic [dmd_pkg::NUM_W-1:0]     message_number,
  output logic                          strobe,
  output logic [7:0]                    out_char,
  output logic                          last,
  output logic                          truncated
);
  import dmd_pkg::*;

  logic     accept;
  logic     we_msg;
  logic     we_word;
  logic     we_woff;
  logic     we_moff;
  logic     go;
  rd_req_t  rq;
  rd_data_t rd;

  assign accept  = start && !busy;
  assign go      = accept && (req_type == REQ_DECODE);
  assign we_msg  = accept && (req_type == REQ_LD_MSG);
  assign we_word = accept && (req_type == REQ_LD_WORD);
  assign we_woff = accept && (req_type == REQ_LD_WOFF);
  assign we_moff = accept && (req_type == REQ_LD_MOFF);

  dmd_store #(.DEPTH(MSG_TEXT_DEPTH), .WIDTH(8), .RA_W(POS_W)) u_msg_text (
    .clk   (clk),
    .we    (we_msg),
    .waddr (load_addr),
    .wdata (load_data[7:0]),
    .raddr (rq.msg_addr),
    .rdata (rd.msg_byte)
  );

  dmd_store #(.DEPTH(WORD_TEXT_DEPTH), .WIDTH(8), .RA_W(POS_W)) u_word_text (
    .clk   (clk),
    .we    (we_word),
    .waddr (load_addr),
    .wdata (load_data[7:0]),
    .raddr (rq.word_addr),
    .rdata (rd.word_byte)
  );

  dmd_store #(.DEPTH(WORD_COUNT + 1), .WIDTH(OFF_W), .RA_W(WOFF_AW)) u_word_off (
    .clk   (clk),
    .we    (we_woff),
    .waddr (load_addr),
    .wdata (load_data),
    .raddr (rq.woff_addr),
    .rdata (rd.woff)
  );

  dmd_store #(.DEPTH(MSG_COUNT + 1), .WIDTH(OFF_W), .RA_W(MOFF_AW)) u_msg_off (
    .clk   (clk),
    .we    (we_moff),
    .waddr (load_addr),
    .wdata (load_data),
    .raddr (rq.moff_addr),
    .rdata (rd.moff)
  );

  dmd_walker #(.MAX_CHARS(MAX_CHARS)) u_walker (
    .clk            (clk),
    .rst            (rst),
    .go             (go),
    .message_number (message_number),
    .rd             (rd),
    .rq             (rq),
    .busy           (busy),
    .strobe         (strobe),
    .out_char       (out_char),
    .last           (last),
    .truncated      (truncated)
  );

endmodule

// File: rtl/core/dmd_store.sv
// One store: single write port, one registered read port, zero out of range.
// Depends on dmd_pkg.
module dmd_store #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8,
  parameter int RA_W  = 14
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [dmd_pkg::LOAD_AW-1:0] waddr,
  input  logic [WIDTH-1:0]            wdata,
  input  logic [RA_W-1:0]             raddr,
  output logic [WIDTH-1:0]            rdata
);
  import dmd_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int MW = (LOAD_AW > RA_W) ? LOAD_AW : RA_W;
  localparam int XW = ((AW > MW) ? AW : MW) + 1;

  logic [WIDTH-1:0] mem [DEPTH];
  logic [XW-1:0]    wa_x;
  logic [XW-1:0]    ra_x;
  logic [WIDTH-1:0] rd_q;
  logic             oob_q;

  assign wa_x = XW'(waddr);
  assign ra_x = XW'(raddr);

  always_ff @(posedge clk) begin
    if (we && (wa_x < XW'(DEPTH))) begin
      mem[wa_x[AW-1:0]] <= wdata;
    end
    rd_q  <= mem[ra_x[AW-1:0]];
    oob_q <= (ra_x >= XW'(DEPTH));
  end

  assign rdata = oob_q ? '0 : rd_q;

endmodule

// File: rtl/core/dmd_walker.sv
// Decode sequencer: walks message leaders, word and literal ranges, emits items.
// Depends on dmd_pkg; drives the read ports of the four stores.
module dmd_walker #(
  parameter int MAX_CHARS = 63
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [dmd_pkg::NUM_W-1:0] message_number,
  input  dmd_pkg::rd_data_t         rd,
  output dmd_pkg::rd_req_t          rq,
  output logic                      busy,
  output logic                      strobe,
  output logic [7:0]                out_char,
  output logic                      last,
  output logic                      truncated
);
  import dmd_pkg::*;

  localparam int SAT   = MAX_CHARS + 2;
  localparam int LEN_W = $clog2(SAT + 1);
  localparam int SUM_W = LEN_W + POS_W;

  st_t               state;
  st_t               state_next;
  logic [NUM_W-1:0]  num;
  logic [POS_W-1:0]  pos;
  logic [OFF_W-1:0]  stop;
  logic [7:0]        lead;
  logic [WIDX_W-1:0] idx;
  logic [POS_W-1:0]  ri;
  logic [POS_W-1:0]  re;
  logic [LEN_W-1:0]  len;
  logic              pend;
  logic              char_pend;
  logic              char_word;
  logic              from_word;

  logic              walk_more;
  logic              in_run;
  logic              room;
  logic [POS_W-1:0]  rest;
  logic [SUM_W-1:0]  len_add;
  logic [LEN_W-1:0]  len_skip;
  logic [LEN_W-1:0]  len_inc;

  assign walk_more = (pos < POS_W'(stop)) && (len < LEN_W'(SAT));
  assign in_run    = ri < re;
  assign room      = len < LEN_W'(MAX_CHARS);
  assign rest      = re - ri;
  assign len_add   = SUM_W'(len) + SUM_W'(rest);
  assign len_skip  = (len_add >= SUM_W'(SAT)) ? LEN_W'(SAT) : len_add[LEN_W-1:0];
  assign len_inc   = (len == LEN_W'(SAT)) ? len : len + 1'b1;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (go) state_next = ST_MOFF0;
      ST_MOFF0:  state_next = ST_MOFF1;
      ST_MOFF1:  state_next = ST_MOFF2;
      ST_MOFF2:  state_next = ST_LOOP;
      ST_LOOP:   state_next = walk_more ? ST_LEAD : ST_FLUSH;
      ST_LEAD: begin
        if (rd.msg_byte[CODE_BIT]) begin
          state_next = rd.msg_byte[WIDE_BIT] ? ST_IDX2 : ST_WOFF0;
        end else begin
          state_next = ST_RSTART;
        end
      end
      ST_IDX2:   state_next = ST_WOFF0;
      ST_WOFF0:  state_next = ST_WOFF1;
      ST_WOFF1:  state_next = ST_WOFF2;
      ST_WOFF2:  state_next = ST_RSTART;
      ST_RSTART: state_next = ST_RANGE;
      ST_RANGE:  if (!in_run) state_next = ST_LOOP;
      ST_FLUSH:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    busy         = (state != ST_IDLE);
    rq.msg_addr  = (state == ST_RANGE) ? ri : pos;
    rq.word_addr = ri;
    rq.woff_addr = (state == ST_WOFF0) ? WOFF_AW'(idx) : WOFF_AW'(idx) + 1'b1;
    rq.moff_addr = (state == ST_MOFF0) ? MOFF_AW'(num) : MOFF_AW'(num) + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      strobe    <= 1'b0;
      last      <= 1'b0;
      truncated <= 1'b0;
      char_pend <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      strobe    <= 1'b0;
      last      <= 1'b0;
      truncated <= 1'b0;
      char_pend <= 1'b0;
      if (char_pend) begin
        strobe   <= 1'b1;
        out_char <= char_word ? rd.word_byte : rd.msg_byte;
      end
      unique case (state)
        ST_IDLE: begin
          if (go) begin
            num  <= message_number;
            len  <= '0;
            pend <= 1'b0;
          end
        end
        ST_MOFF0: begin
        end
        ST_MOFF1:  pos  <= POS_W'(rd.moff);
        ST_MOFF2:  stop <= rd.moff;
        ST_LOOP:   if (walk_more) pos <= pos + 1'b1;
        ST_LEAD: begin
          lead <= rd.msg_byte;
          if (rd.msg_byte[CODE_BIT]) begin
            if (rd.msg_byte[WIDE_BIT]) begin
              pos <= pos + 1'b1;
            end else begin
              idx <= WIDX_W'(rd.msg_byte[6:0]);
            end
          end else begin
            ri        <= pos;
            re        <= pos + POS_W'(rd.msg_byte);
            pos       <= pos + POS_W'(rd.msg_byte);
            from_word <= 1'b0;
          end
        end
        ST_IDX2:   idx <= {lead[5:0], rd.msg_byte};
        ST_WOFF0: begin
        end
        ST_WOFF1:  ri <= POS_W'(rd.woff);
        ST_WOFF2: begin
          re        <= POS_W'(rd.woff);
          from_word <= 1'b1;
        end
        ST_RSTART: begin
          // a held space is emitted once the next range starts, even when that range is empty
          if (pend) begin
            strobe   <= 1'b1;
            out_char <= SPACE_CHAR;
            pend     <= 1'b0;
          end
        end
        ST_RANGE: begin
          if (in_run) begin
            if (room) begin
              char_pend <= 1'b1;
              char_word <= from_word;
              ri        <= ri + 1'b1;
              len       <= len + 1'b1;
            end else begin
              len <= len_skip;
              ri  <= re;
            end
          end else begin
            if (room) pend <= 1'b1;
            len <= len_inc;
          end
        end
        ST_FLUSH: begin
          strobe    <= 1'b1;
          out_char  <= NUL_CHAR;
          last      <= 1'b1;
          truncated <= (len == LEN_W'(SAT));
          pend      <= 1'b0;
        end
      endcase
    end
  end

endmodule

// File: rtl/core/dmd_checker.sv
// Port-level checks of the dictionary message decoder, bound to the top level.
// Depends on dictionary_message_decoder_core_defines.svh.
`include "dictionary_message_decoder_core_defines.svh"

module dmd_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       strobe,
  input logic [7:0] out_char,
  input logic       last,
  input logic       truncated
);

  `DMD_ASSERT_NEXT(a_accept_quiet, clk, rst, start && !busy, !strobe)
  `DMD_ASSERT_NOW(a_term_when_idle, clk, rst, strobe, busy != last)
  `DMD_ASSERT_NOW(a_flags_need_strobe, clk, rst, !strobe, !last && !truncated)
  `DMD_ASSERT_NOW(a_trunc_on_last, clk, rst, truncated, last)
  `DMD_ASSERT_NOW(a_term_is_zero, clk, rst, strobe && last, out_char == 8'h00)

endmodule

bind dictionary_message_decoder_core dmd_checker u_dmd_checker (.*);

// File: bench/tb_dictionary_message_decoder_core.sv
// Testbench for dictionary_message_decoder_core: loads the four stores and decodes messages,
// checking every emitted character and terminator against a built-in predictor.
// Depends on dmd_pkg and the core RTL; entries are loaded on demand before each decode.
module tb_dictionary_message_decoder_core;
  import dmd_pkg::*;

  localparam int MSG_DEPTH   = 4096;
  localparam int WORD_DEPTH  = 4096;
  localparam int WORD_COUNT  = 1024;
  localparam int MSG_COUNT   = 512;
  localparam int LINE_MAX    = 63;
  localparam int OFF_LIMIT   = 4096;
  localparam int ITEM_GOAL   = 210;
  localparam int DECODE_GOAL = 20;
  localparam logic [2:0] REQ_UNKNOWN_FIRST = 3'd5;
  localparam logic [2:0] REQ_UNKNOWN_LAST  = 3'd7;
  localparam int IDLE_PHASES [4] = '{0, 51, 0, 23};

  typedef enum {STORE_NONE, STORE_MSG, STORE_WORD, STORE_WOFF, STORE_MOFF} store_t;

  typedef struct {
    logic [7:0] code;
    logic       eom;
    logic       cut;
  } glyph_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         req_type = REQ_DECODE;
  logic [LOAD_AW-1:0] load_addr = '0;
  logic [OFF_W-1:0]   load_data = '0;
  logic [NUM_W-1:0]   message_number = '0;
  logic               strobe;
  logic [7:0]         out_char;
  logic               last;
  logic               truncated;

  // Predictor state
  logic [7:0]       msg_bytes  [MSG_DEPTH];
  logic [7:0]       word_bytes [WORD_DEPTH];
  logic [OFF_W-1:0] woff      [WORD_COUNT+1];
  logic [OFF_W-1:0] moff      [MSG_COUNT+1];
  bit               msg_w     [MSG_DEPTH];
  bit               word_w    [WORD_DEPTH];
  bit               woff_w    [WORD_COUNT+1];
  bit               moff_w    [MSG_COUNT+1];

  logic [7:0]  line_buf [LINE_MAX];
  int unsigned line_len;
  glyph_t      decoded_line[$];
  glyph_t      expected_glyphs[$];
  store_t      miss_kind;
  int unsigned miss_addr;

  int idle_pct;
  int fail_count;
  int items_taken;
  int decodes_sent;

  dictionary_message_decoder_core #(
    .MSG_TEXT_DEPTH (MSG_DEPTH),
    .WORD_TEXT_DEPTH(WORD_DEPTH),
    .WORD_COUNT     (WORD_COUNT),
    .MSG_COUNT      (MSG_COUNT),
    .MAX_CHARS      (LINE_MAX)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .load_addr     (load_addr),
    .load_data     (load_data),
    .message_number(message_number),
    .strobe        (strobe),
    .out_char      (out_char),
    .last          (last),
    .truncated     (truncated)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string what);
    if (fail_count < 40) $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic void note_miss(input store_t kind, input int unsigned a);
    if (miss_kind == STORE_NONE) begin
      miss_kind = kind;
      miss_addr = a;
    end
  endfunction

  function automatic logic [7:0] rd_msg(input int unsigned a);
    if (a >= MSG_DEPTH) return 8'h00;
    if (!msg_w[a]) note_miss(STORE_MSG, a);
    return msg_bytes[a];
  endfunction

  function automatic logic [7:0] rd_word(input int unsigned a);
    if (a >= WORD_DEPTH) return 8'h00;
    if (!word_w[a]) note_miss(STORE_WORD, a);
    return word_bytes[a];
  endfunction

  function automatic int unsigned rd_woff(input int unsigned a);
    if (a > WORD_COUNT) return 0;
    if (!woff_w[a]) note_miss(STORE_WOFF, a);
    return woff[a];
  endfunction

  function automatic int unsigned rd_moff(input int unsigned a);
    if (a > MSG_COUNT) return 0;
    if (!moff_w[a]) note_miss(STORE_MOFF, a);
    return moff[a];
  endfunction

  function automatic void put_char(input logic [7:0] c);
    if (line_len < LINE_MAX) line_buf[line_len] = c;
    line_len++;
  endfunction

  // Copy bytes [s, e) of one text store, then a space; bytes past the limit are only counted.
  function automatic void put_span(input bit from_words, input int unsigned s,
                                   input int unsigned e);
    int unsigned i;
    i = s;
    while (i < e && line_len < LINE_MAX) begin
      put_char(from_words ? rd_word(i) : rd_msg(i));
      i++;
    end
    if (i < e) line_len += e - i;
    put_char(SPACE_CHAR);
  endfunction

  function automatic void walk_message(input int unsigned num);
    int unsigned pos, stop, lead, idx, content, shown, k;
    glyph_t g;
    miss_kind = STORE_NONE;
    line_len = 0;
    decoded_line.delete();
    pos = rd_moff(num);
    stop = rd_moff(num + 1);
    while (pos < stop) begin
      lead = rd_msg(pos);
      pos++;
      if (lead[CODE_BIT]) begin
        if (lead[WIDE_BIT]) begin
          idx = ((lead & 'h3F) << 8) | rd_msg(pos);
          pos++;
        end else begin
          idx = lead & 'h7F;
        end
        put_span(1'b1, rd_woff(idx), rd_woff(idx + 1));
      end else begin
        put_span(1'b0, pos, pos + lead);
        pos += lead;
      end
    end
    content = (line_len != 0) ? line_len - 1 : 0;
    shown = (content < LINE_MAX) ? content : LINE_MAX;
    for (k = 0; k < shown; k++) begin
      g.code = line_buf[k];
      g.eom = 1'b0;
      g.cut = 1'b0;
      decoded_line.push_back(g);
    end
    g.code = NUL_CHAR;
    g.eom = 1'b1;
    g.cut = content > LINE_MAX;
    decoded_line.push_back(g);
  endfunction

  task automatic send_item(input logic [2:0] kind, input int unsigned addr,
                           input int unsigned data, input int unsigned num);
    bit taken;
    taken = 1'b0;
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start = 1'b1;
    req_type = kind;
    load_addr = addr[LOAD_AW-1:0];
    load_data = data[OFF_W-1:0];
    message_number = num[NUM_W-1:0];
    do @(posedge clk); while (busy);
    case (kind)
      REQ_DECODE: begin
        walk_message(num[NUM_W-1:0]);
        foreach (decoded_line[i]) expected_glyphs.push_back(decoded_line[i]);
        decodes_sent++;
        taken = 1'b1;
      end
      REQ_LD_MSG: begin
        msg_bytes[addr[LOAD_AW-1:0]] = data[7:0];
        msg_w[addr[LOAD_AW-1:0]] = 1'b1;
        taken = 1'b1;
      end
      REQ_LD_WORD: begin
        word_bytes[addr[LOAD_AW-1:0]] = data[7:0];
        word_w[addr[LOAD_AW-1:0]] = 1'b1;
        taken = 1'b1;
      end
      REQ_LD_WOFF: if (addr <= WORD_COUNT) begin
        woff[addr] = data[OFF_W-1:0];
        woff_w[addr] = 1'b1;
        taken = 1'b1;
      end
      REQ_LD_MOFF: if (addr <= MSG_COUNT) begin
        moff[addr] = data[OFF_W-1:0];
        moff_w[addr] = 1'b1;
        taken = 1'b1;
      end
      default: ;
    endcase
    if (taken) items_taken++;
  endtask

  function automatic int clamp_off(input int v);
    if (v < 0) return 0;
    if (v > OFF_LIMIT) return OFF_LIMIT;
    return v;
  endfunction

  // Mostly word codes and short literal runs, now and then a long run.
  function automatic int unsigned leader_data();
    int unsigned r;
    logic [7:0] b;
    r = $urandom_range(0, 99);
    if (r < 35) b = {1'b1, 7'($urandom_range(0, 127))};
    else if (r < 45) b = {2'b11, 6'($urandom_range(0, 5))};
    else if (r < 50) b = {2'b11, 6'($urandom_range(0, 63))};
    else if (r < 94) b = 8'($urandom_range(0, 8));
    else b = 8'($urandom_range(0, 127));
    return {$urandom_range(0, 15), b};
  endfunction

  // Load the entry the last prediction read before it was written.
  task automatic fill_gap(input int unsigned num);
    int unsigned a;
    int spread;
    a = miss_addr;
    case (miss_kind)
      STORE_MSG: send_item(REQ_LD_MSG, a, leader_data(), 0);
      STORE_WORD: send_item(REQ_LD_WORD, a, $urandom_range(0, OFF_LIMIT), 0);
      STORE_WOFF: begin
        spread = int'($urandom_range(0, 8));
        if ($urandom_range(0, 9) == 0) spread = -int'($urandom_range(1, 4));
        if (a > 0 && woff_w[a-1])
          send_item(REQ_LD_WOFF, a, clamp_off(int'(woff[a-1]) + spread), 0);
        else if (a < WORD_COUNT && woff_w[a+1])
          send_item(REQ_LD_WOFF, a, clamp_off(int'(woff[a+1]) - spread), 0);
        else
          send_item(REQ_LD_WOFF, a, $urandom_range(0, OFF_LIMIT), 0);
      end
      STORE_MOFF: begin
        spread = int'($urandom_range(0, 14));
        if ($urandom_range(0, 7) == 0) spread = -int'($urandom_range(1, 4));
        if (a == num + 1)
          send_item(REQ_LD_MOFF, a, clamp_off(int'(moff[num]) + spread), 0);
        else if (a < MSG_COUNT && moff_w[a+1])
          send_item(REQ_LD_MOFF, a, clamp_off(int'(moff[a+1]) - spread), 0);
        else
          send_item(REQ_LD_MOFF, a, clamp_off(int'(a) * 8 + spread), 0);
      end
      default: ;
    endcase
  endtask

  task automatic decode_message(input int unsigned num);
    walk_message(num);
    while (miss_kind != STORE_NONE) begin
      fill_gap(num);
      walk_message(num);
    end
    send_item(REQ_DECODE, $urandom_range(0, 4095), $urandom_range(0, OFF_LIMIT), num);
  endtask

  task automatic test_empty_messages();
    send_item(REQ_LD_MOFF, 0, 10, 0);
    send_item(REQ_LD_MOFF, 1, 10, 0);
    send_item(REQ_LD_MOFF, 2, 5, 0);
    decode_message(0);
    decode_message(1);
  endtask

  // Short code, wide codes at and past the table end, a literal run, and a wide
  // code whose second byte lies past the message end.
  task automatic test_word_codes();
    logic [7:0] text [10] = '{8'h81, 8'hC4, 8'h00, 8'hFF, 8'hFF,
                              8'h02, 8'h78, 8'h79, 8'hC0, 8'h01};
    send_item(REQ_LD_WOFF, 1, 4094, 0);
    send_item(REQ_LD_WOFF, 2, 4096, 0);
    send_item(REQ_LD_WOFF, WORD_COUNT, 4095, 0);
    send_item(REQ_LD_WORD, 4094, 8'hFF, 0);
    send_item(REQ_LD_WORD, 4095, 8'h01, 0);
    send_item(REQ_LD_MOFF, 3, 14, 0);
    foreach (text[i]) send_item(REQ_LD_MSG, 5 + i, text[i], 0);
    decode_message(2);
  endtask

  task automatic test_ignored_items();
    for (logic [2:0] t = REQ_UNKNOWN_FIRST; t <= REQ_UNKNOWN_LAST && t != 0; t++)
      send_item(t, $urandom_range(0, 4095), $urandom_range(0, OFF_LIMIT),
                $urandom_range(0, 511));
    send_item(REQ_LD_WOFF, 4095, 0, 0);
    send_item(REQ_LD_MOFF, 600, 4096, 0);
    decode_message(2);
  endtask

  // Literal runs reaching past the store end: 63 characters exactly, then two truncations.
  task automatic test_long_runs();
    send_item(REQ_LD_MOFF, 509, 4093, 0);
    send_item(REQ_LD_MOFF, 510, 4094, 0);
    send_item(REQ_LD_MOFF, 511, 4095, 0);
    send_item(REQ_LD_MOFF, 512, 4096, 0);
    send_item(REQ_LD_MSG, 4093, 8'h3F, 0);
    send_item(REQ_LD_MSG, 4094, 8'h7F, 0);
    send_item(REQ_LD_MSG, 4095, 8'h40, 0);
    decode_message(509);
    decode_message(510);
    decode_message(511);
  endtask

  task automatic test_random_traffic();
    int unsigned r;
    while (items_taken < ITEM_GOAL || decodes_sent < DECODE_GOAL) begin
      idle_pct = IDLE_PHASES[(items_taken * 4 / ITEM_GOAL) % 4];
      r = $urandom_range(0, 99);
      if (r < 60) begin
        if ($urandom_range(0, 4) == 0) decode_message($urandom_range(0, 511));
        else decode_message($urandom_range(0, 23));
      end else if (r < 85) begin
        case ($urandom_range(0, 2))
          0: send_item(REQ_LD_MSG, $urandom_range(0, MSG_DEPTH - 1),
                       $urandom_range(0, OFF_LIMIT), 0);
          1: send_item(REQ_LD_WORD, $urandom_range(0, WORD_DEPTH - 1),
                       $urandom_range(0, OFF_LIMIT), 0);
          default: send_item(REQ_LD_WOFF, $urandom_range(0, WORD_COUNT),
                             $urandom_range(0, OFF_LIMIT), 0);
        endcase
      end else begin
        case ($urandom_range(0, 2))
          0: send_item(3'($urandom_range(REQ_UNKNOWN_FIRST, REQ_UNKNOWN_LAST)),
                       $urandom_range(0, 4095), $urandom_range(0, 8191),
                       $urandom_range(0, 511));
          1: send_item(REQ_LD_WOFF, $urandom_range(WORD_COUNT + 1, 4095),
                       $urandom_range(0, OFF_LIMIT), 0);
          default: send_item(REQ_LD_MOFF, $urandom_range(MSG_COUNT + 1, 4095),
                             $urandom_range(0, OFF_LIMIT), 0);
        endcase
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    glyph_t want;
    if (!rst && strobe) begin
      if (expected_glyphs.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected: char %h last %b",
                                  out_char, last));
      end else begin
        want = expected_glyphs.pop_front();
        if (out_char !== want.code)
          report_mismatch($sformatf("out_char %h, expected %h", out_char, want.code));
        if (last !== want.eom)
          report_mismatch($sformatf("last %b, expected %b", last, want.eom));
        if (truncated !== want.cut)
          report_mismatch($sformatf("truncated %b, expected %b", truncated, want.cut));
      end
    end
  end

  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    idle_pct = 0;
    fail_count = 0;
    items_taken = 0;
    decodes_sent = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_empty_messages();
    test_word_codes();
    test_ignored_items();
    test_long_runs();
    test_random_traffic();
    @(negedge clk);
    start = 1'b0;
    while (expected_glyphs.size() != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/dmd_pkg.sv
rtl/core/dmd_store.sv
rtl/core/dmd_walker.sv
rtl/core/dictionary_message_decoder_core.sv
rtl/core/dmd_checker.sv
bench/tb_dictionary_message_decoder_core.sv
